>>> design/npc_pkg.sv
// Shared types and constants for the nearest palette color block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  localparam int PaletteDepth = 256;
  localparam int IdxW         = 8;
  localparam int CompW        = 8;
  localparam int CfgW         = 9;
  localparam int SqW          = 2 * CompW;
  localparam int DistW        = SqW + 2;
  localparam int QueueDepth   = 2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] entry_index;
    rgb_t            color;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

>>> design/npc_channels.sv
// Valid/ready channel interfaces for input items and lookup results.
// Depends on npc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface npc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [npc_pkg::IdxW-1:0]   entry_index;
  logic [npc_pkg::CompW-1:0]  red;
  logic [npc_pkg::CompW-1:0]  green;
  logic [npc_pkg::CompW-1:0]  blue;

  modport source (output valid, output cmd, output entry_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input cmd, input entry_index, input red,
                  input green, input blue, output ready);
endinterface

interface npc_out_if;
  logic                     valid;
  logic                     ready;
  logic [npc_pkg::IdxW-1:0] nearest_index;

  modport source (output valid, output nearest_index, input ready);
  modport sink   (input valid, input nearest_index, output ready);
endinterface

`default_nettype wire

>>> design/npc_front.sv
// Front end: accepts input transactions, decodes the command and drops
// writes outside the palette. Depends on npc_pkg and npc_channels.
`timescale 1ns / 1ps
`default_nettype none

module npc_front #(
  parameter int PALETTE_DEPTH = npc_pkg::PaletteDepth
) (
  npc_in_if.sink          in_i,
  input  wire logic       full_i,
  output npc_pkg::item_t  push_item_o,
  output logic            push_valid_o
);

  localparam int RangeW = npc_pkg::IdxW + 1;

  logic keep;

  always_comb begin
    push_item_o.op          = npc_pkg::op_e'(in_i.cmd);
    push_item_o.entry_index = in_i.entry_index;
    push_item_o.color.red   = in_i.red;
    push_item_o.color.green = in_i.green;
    push_item_o.color.blue  = in_i.blue;
    keep = (push_item_o.op == npc_pkg::OP_LOOKUP) ||
           (RangeW'(in_i.entry_index) < RangeW'(PALETTE_DEPTH));
  end

  assign in_i.ready   = !full_i;
  assign push_valid_o = in_i.valid && !full_i && keep;

endmodule

`default_nettype wire

>>> design/npc_queue.sv
// Short FIFO of decoded items between front end and scan engine.
// Depends on npc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire npc_pkg::item_t       push_item_i,
  input  wire logic                 push_valid_i,
  output logic                      full_o,
  output npc_pkg::queue_head_t      head_o,
  input  wire logic                 pop_i
);

  localparam int PtrW = (npc_pkg::QueueDepth > 1) ? $clog2(npc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(npc_pkg::QueueDepth + 1);

  npc_pkg::item_t  entries_q [npc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(npc_pkg::QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(npc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(npc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> design/npc_back.sv
// Scan engine: palette memory, pipelined distance search and result register.
// Holds the colors_in_use register. Depends on npc_pkg and npc_channels.
`timescale 1ns / 1ps
`default_nettype none

module npc_back #(
  parameter int PALETTE_DEPTH = npc_pkg::PaletteDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire npc_pkg::queue_head_t       head_i,
  output logic                            pop_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [npc_pkg::CfgW-1:0]   cfg_data_i,
  npc_out_if.source                       out_o
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(PALETTE_DEPTH + 1);

  npc_pkg::rgb_t mem [PALETTE_DEPTH];

  npc_pkg::state_e state_q, state_d;

  logic [npc_pkg::CfgW-1:0]  cfg_q;
  logic [CW-1:0]             count_sat;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             issue_q, issue_d;
  npc_pkg::rgb_t             pixel_q;

  logic                      wr_en, rd_en, start, load_out;
  npc_pkg::rgb_t             rd_data_q;
  logic                      v1_q, v2_q;
  logic [AW-1:0]             idx1_q, idx2_q;
  logic [npc_pkg::SqW-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [npc_pkg::DistW-1:0] cand_dist;
  logic                      update;
  logic                      have_best_q;
  logic [npc_pkg::DistW-1:0] best_dist_q;
  logic [AW-1:0]             best_idx_q;
  logic                      out_valid_q;
  logic [npc_pkg::IdxW-1:0]  out_idx_q;

  function automatic logic [npc_pkg::SqW-1:0] sq_diff(
    input logic [npc_pkg::CompW-1:0] a,
    input logic [npc_pkg::CompW-1:0] b
  );
    logic [npc_pkg::CompW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return npc_pkg::SqW'(d) * npc_pkg::SqW'(d);
  endfunction

  assign count_sat = (cfg_q > npc_pkg::CfgW'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                              : CW'(cfg_q);

  always_comb begin
    state_d  = state_q;
    issue_d  = issue_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      npc_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.op == npc_pkg::OP_WRITE) begin
            wr_en = 1'b1;
          end else begin
            start   = 1'b1;
            issue_d = '0;
            state_d = npc_pkg::ST_SCAN;
          end
        end
      end
      npc_pkg::ST_SCAN: begin
        if (issue_q < count_q) begin
          rd_en   = 1'b1;
          issue_d = issue_q + 1'b1;
        end else if (!v1_q && !v2_q) begin
          state_d = npc_pkg::ST_FINISH;
        end
      end
      npc_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = npc_pkg::ST_IDLE;
      end
    endcase
  end

  assign cand_dist = npc_pkg::DistW'(sq_r_q) + npc_pkg::DistW'(sq_g_q) +
                     npc_pkg::DistW'(sq_b_q);
  assign update    = v2_q && (!have_best_q || (cand_dist < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npc_pkg::ST_IDLE;
      cfg_q       <= npc_pkg::CfgW'(npc_pkg::PaletteDepth);
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (start) begin
        count_q     <= count_sat;
        have_best_q <= 1'b0;
      end else if (update) begin
        have_best_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[head_i.item.entry_index[AW-1:0]] <= head_i.item.color;
    end
    if (rd_en) begin
      rd_data_q <= mem[issue_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pixel_q    <= head_i.item.color;
      best_idx_q <= '0;
    end else if (update) begin
      best_idx_q  <= idx2_q;
      best_dist_q <= cand_dist;
    end
    idx1_q <= issue_q[AW-1:0];
    idx2_q <= idx1_q;
    sq_r_q <= sq_diff(rd_data_q.red,   pixel_q.red);
    sq_g_q <= sq_diff(rd_data_q.green, pixel_q.green);
    sq_b_q <= sq_diff(rd_data_q.blue,  pixel_q.blue);
    if (load_out) begin
      out_idx_q <= npc_pkg::IdxW'(best_idx_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.nearest_index = out_idx_q;

endmodule

`default_nettype wire

>>> design/nearest_palette_color.sv
// Nearest palette color: top level joining front end, item queue and scan engine.
// Write: performed by the scan engine when it pops the item. Lookup: one palette read
// per cycle for each color in use, through a two-stage distance pipeline, then the result
// register is loaded once it is free; the next item starts after that.
// Results wait in an output register. Reset clears control state and sets
// colors_in_use to 256; the palette memory is not cleared (undefined until written).
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color #(
  parameter int PALETTE_DEPTH = npc_pkg::PaletteDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  npc_in_if.sink                        in_i,
  npc_out_if.source                     out_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [npc_pkg::CfgW-1:0] cfg_data_i
);

  npc_pkg::item_t       push_item;
  logic                 push_valid;
  logic                 full;
  npc_pkg::queue_head_t head;
  logic                 pop;

  npc_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .in_i         (in_i),
    .full_i       (full),
    .push_item_o  (push_item),
    .push_valid_o (push_valid)
  );

  npc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .full_o       (full),
    .head_o       (head),
    .pop_i        (pop)
  );

  npc_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for nearest_palette_color: palette writes and nearest-color lookups,
// each lookup checked against a palette-scan predictor kept in this file.
// Depends on npc_pkg and the npc_in_if / npc_out_if channel interfaces.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit   = 1_500_000;
  localparam int SettleCycles = 12;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [npc_pkg::CfgW-1:0] cfg_data_i;

  npc_in_if  in_ch ();
  npc_out_if out_ch ();

  nearest_palette_color dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  npc_pkg::rgb_t            palette_model [npc_pkg::PaletteDepth];
  int unsigned              colors_cfg;
  logic [npc_pkg::IdxW-1:0] pending_indices [$];
  logic [npc_pkg::IdxW-1:0] want_index;
  int                       mismatch_count;
  int                       cycle_count;
  bit                       gaps_enabled;
  int                       hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [npc_pkg::IdxW-1:0] nearest_in_palette(input npc_pkg::rgb_t px);
    int unsigned              span;
    int unsigned              sq_sum;
    int unsigned              best_dist;
    int                       dr;
    int                       dg;
    int                       db;
    logic [npc_pkg::IdxW-1:0] best;
    span      = (colors_cfg > npc_pkg::PaletteDepth) ? npc_pkg::PaletteDepth : colors_cfg;
    best      = '0;
    best_dist = 32'hFFFF_FFFF;
    for (int i = 0; i < span; i++) begin
      dr     = int'(palette_model[i].red) - int'(px.red);
      dg     = int'(palette_model[i].green) - int'(px.green);
      db     = int'(palette_model[i].blue) - int'(px.blue);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best      = i[npc_pkg::IdxW-1:0];
      end
    end
    return best;
  endfunction

  function automatic npc_pkg::rgb_t random_color();
    npc_pkg::rgb_t c;
    c.red   = npc_pkg::CompW'($urandom_range(0, 255));
    c.green = npc_pkg::CompW'($urandom_range(0, 255));
    c.blue  = npc_pkg::CompW'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [npc_pkg::CompW-1:0] jitter(input logic [npc_pkg::CompW-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[npc_pkg::CompW-1:0];
  endfunction

  function automatic npc_pkg::rgb_t mk_rgb(input int r, input int g, input int b);
    npc_pkg::rgb_t c;
    c.red   = r[npc_pkg::CompW-1:0];
    c.green = g[npc_pkg::CompW-1:0];
    c.blue  = b[npc_pkg::CompW-1:0];
    return c;
  endfunction

  // one transaction on the input channel; the prediction is made on acceptance
  task automatic push_item(input npc_pkg::op_e op, input logic [npc_pkg::IdxW-1:0] idx,
                           input npc_pkg::rgb_t c);
    int gap;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid       = 1'b1;
    in_ch.cmd         = op;
    in_ch.entry_index = idx;
    in_ch.red         = c.red;
    in_ch.green       = c.green;
    in_ch.blue        = c.blue;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == npc_pkg::OP_WRITE) begin
      palette_model[idx] = c;
    end else begin
      pending_indices.push_back(nearest_in_palette(c));
    end
  endtask

  task automatic lookup(input npc_pkg::rgb_t px);
    push_item(npc_pkg::OP_LOOKUP, npc_pkg::IdxW'($urandom_range(0, 255)), px);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_indices.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_colors(input int unsigned count);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = count[npc_pkg::CfgW-1:0];
    colors_cfg = count;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_indices.size() == 0) begin
        report_mismatch($sformatf("unexpected result nearest_index=%0d",
                                  out_ch.nearest_index));
      end else begin
        want_index = pending_indices.pop_front();
        if (out_ch.nearest_index !== want_index) begin
          report_mismatch($sformatf("nearest_index got %0d want %0d",
                                    out_ch.nearest_index, want_index));
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left   = $urandom_range(1, 9) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // palette fully written first, so no lookup ever reads an unwritten entry
  task automatic test_fill_at_reset_count();
    gaps_enabled = 1'b1;
    for (int i = 0; i < npc_pkg::PaletteDepth; i++) begin
      push_item(npc_pkg::OP_WRITE, i[npc_pkg::IdxW-1:0], random_color());
    end
    repeat (4) lookup(random_color());
  endtask

  task automatic test_directed();
    set_colors(0);
    lookup(mk_rgb(0, 0, 0));
    lookup(mk_rgb(255, 255, 255));
    push_item(npc_pkg::OP_WRITE, 8'd0, mk_rgb(0, 0, 0));
    push_item(npc_pkg::OP_WRITE, 8'd1, mk_rgb(255, 255, 255));
    push_item(npc_pkg::OP_WRITE, 8'd2, mk_rgb(128, 64, 32));
    push_item(npc_pkg::OP_WRITE, 8'd3, mk_rgb(128, 64, 32));
    push_item(npc_pkg::OP_WRITE, 8'd4, mk_rgb(20, 0, 0));
    push_item(npc_pkg::OP_WRITE, 8'd5, mk_rgb(0, 0, 20));
    push_item(npc_pkg::OP_WRITE, 8'd255, mk_rgb(200, 10, 90));
    set_colors(1);
    lookup(mk_rgb(255, 255, 255));
    set_colors(4);
    lookup(mk_rgb(255, 255, 255));
    lookup(mk_rgb(128, 64, 32));
    lookup(mk_rgb(129, 64, 32));
    set_colors(6);
    lookup(mk_rgb(10, 0, 10));
    lookup(mk_rgb(20, 0, 10));
    set_colors(npc_pkg::PaletteDepth);
    lookup(mk_rgb(200, 10, 90));
    lookup(mk_rgb(0, 255, 0));
    set_colors(511);
    lookup(mk_rgb(200, 10, 90));
    lookup(mk_rgb(255, 0, 255));
    set_colors(257);
    lookup(mk_rgb(0, 0, 0));
  endtask

  task automatic test_random_mix(input int phases, input int per_phase);
    int unsigned   span;
    npc_pkg::rgb_t c;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0:       set_colors(npc_pkg::PaletteDepth);
        1:       set_colors($urandom_range(npc_pkg::PaletteDepth + 1, 511));
        2:       set_colors(0);
        3:       set_colors(1);
        default: set_colors($urandom_range(2, 40));
      endcase
      gaps_enabled = ($urandom_range(0, 3) != 0);
      span = (colors_cfg > npc_pkg::PaletteDepth) ? npc_pkg::PaletteDepth : colors_cfg;
      if (span == 0) span = 1;
      for (int k = 0; k < per_phase; k++) begin
        case ($urandom_range(0, 9))
          0, 1:    push_item(npc_pkg::OP_WRITE,
                             npc_pkg::IdxW'($urandom_range(0, span - 1)), random_color());
          2:       push_item(npc_pkg::OP_WRITE,
                             npc_pkg::IdxW'($urandom_range(0, 255)), random_color());
          3:       push_item(npc_pkg::OP_WRITE,
                             npc_pkg::IdxW'($urandom_range(0, span - 1)),
                             palette_model[$urandom_range(0, span - 1)]);
          4, 5:    lookup(random_color());
          6:       lookup(palette_model[$urandom_range(0, span - 1)]);
          7: begin
            c       = palette_model[$urandom_range(0, span - 1)];
            c.red   = jitter(c.red);
            c.green = jitter(c.green);
            c.blue  = jitter(c.blue);
            lookup(c);
          end
          default: lookup(mk_rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                                 $urandom_range(0, 1) * 255));
        endcase
      end
    end
  endtask

  // receiver holds off while lookups keep coming, so the input stalls
  task automatic test_output_hold();
    set_colors(8);
    gaps_enabled = 1'b0;
    hold_cycles  = 600;
    repeat (12) lookup(random_color());
  endtask

  task automatic test_streaming();
    set_colors($urandom_range(2, 24));
    gaps_enabled = 1'b0;
    for (int k = 0; k < 60; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        push_item(npc_pkg::OP_WRITE, npc_pkg::IdxW'($urandom_range(0, colors_cfg - 1)),
                  random_color());
      end else begin
        lookup(random_color());
      end
    end
  endtask

  initial begin
    mismatch_count    = 0;
    colors_cfg        = npc_pkg::PaletteDepth;
    gaps_enabled      = 1'b0;
    hold_cycles       = 0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = npc_pkg::OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_at_reset_count();
    test_directed();
    test_random_mix(14, 40);
    test_output_hold();
    test_streaming();

    wait_idle();
    repeat (npc_pkg::PaletteDepth + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/npc_pkg.sv
design/npc_channels.sv
design/npc_front.sv
design/npc_queue.sv
design/npc_back.sv
design/nearest_palette_color.sv
dv/tb_top.sv
